// ===== design/quickselect_k_smallest_defines.svh =====
// ---------------------------------------------------------------------------
// quickselect_k_smallest_defines - assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef QUICKSELECT_K_SMALLEST_DEFINES_SVH
`define QUICKSELECT_K_SMALLEST_DEFINES_SVH

`ifndef SYNTHESIS

// Check prop on every clock edge outside reset.
`define QSKS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("quickselect_k_smallest: assertion failed");

// Check that cons holds whenever ante holds.
`define QSKS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    `QSKS_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`else

`define QSKS_ASSERT(label, clk, rst_n, prop)
`define QSKS_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/qsks_pkg.sv =====
// ---------------------------------------------------------------------------
// qsks_pkg - shared constants for the k-smallest selection block
// Field widths, parameter defaults and the select count reset value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qsks_pkg;

    localparam int VALUE_W        = 32;
    localparam int SC_W           = 7;
    localparam int SET_DEPTH_DEF  = 256;
    localparam int MAX_SELECT_DEF = 64;

    localparam logic [SC_W-1:0] SELECT_COUNT_RST = 7'd4;

endpackage

`default_nettype wire

// ===== design/quickselect_k_smallest.sv =====
// ---------------------------------------------------------------------------
// quickselect_k_smallest - k smallest values of a loaded set by quickselect
// Loads a set into on-chip store, partitions in place, emits up to k results.
// ---------------------------------------------------------------------------
// Signed values stream in on the s_ channel, one transaction per cycle
// while loading, and are written to an element store of SET_DEPTH entries
// until a transaction with s_last arrives; values beyond the store depth
// are dropped and the results of that set carry m_overflowed. With k =
// select_count (0 counts as 1, values above MAX_SELECT saturate), a set of
// k or fewer elements is returned whole in load order with m_short_set
// high. Otherwise the block runs quickselect in place, first element of the
// range as pivot, and returns store positions 0..k-1 in partitioned order;
// m_last_out marks the final result. Each partition pass scans a range and
// moves elements across the hole, every step being one access to the
// single-port store (one read or one write a cycle, read data registered);
// passes repeat until the pivot lands at k, so selection is linear in n on
// typical data and quadratic on sorted data. Each result then goes through
// a store read and an output load. The block refuses input from the last
// element of a set until its final result has been loaded into the output
// register; that register then waits for m_ready while the next set loads.
// select_count is written over the cfg_ channel, always ready; the user
// must write it only while the block is idle; the block itself does not
// enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "quickselect_k_smallest_defines.svh"

module quickselect_k_smallest
    import qsks_pkg::*;
#(
    parameter int SET_DEPTH  = SET_DEPTH_DEF,
    parameter int MAX_SELECT = MAX_SELECT_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // configuration write channel: select_count
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [SC_W-1:0]           cfg_data,
    // input channel
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [VALUE_W-1:0] s_value,
    input  wire logic                      s_last,
    // result channel
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [VALUE_W-1:0]      m_value_out,
    output logic                           m_last_out,
    output logic                           m_short_set,
    output logic                           m_overflowed
);

    localparam int AW   = $clog2(SET_DEPTH);
    localparam int CW   = $clog2(SET_DEPTH + 1);
    localparam int CMPW = (CW > SC_W) ? CW : SC_W;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PIV_RD,
        S_PIV_LATCH,
        S_HI_CHK,
        S_HI_TEST,
        S_LO_CHK,
        S_LO_TEST,
        S_PLACE,
        S_EMIT_RD,
        S_EMIT_WAIT
    } state_t;

    // element store
    logic signed [VALUE_W-1:0] element_store_mem [SET_DEPTH];
    logic signed [VALUE_W-1:0] rdata_reg;

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic signed [VALUE_W-1:0] mem_wdata;
    logic                      mem_re;
    logic [AW-1:0]             mem_raddr;

    // control and datapath registers
    state_t                    state_reg;
    logic [SC_W-1:0]           select_count_reg;
    logic [CW-1:0]             load_count_reg;
    logic                      overflow_seen_reg;
    logic [SC_W-1:0]           k_reg;
    logic [CMPW-1:0]           n_out_reg;
    logic [AW-1:0]             range_low_reg;
    logic [AW-1:0]             range_high_reg;
    logic [AW-1:0]             lo_reg;
    logic [AW-1:0]             hi_reg;
    logic signed [VALUE_W-1:0] pivot_value_reg;
    logic [AW-1:0]             out_idx_reg;
    logic                      short_reg;
    logic                      ovf_reg;

    logic                      m_valid_reg;
    logic signed [VALUE_W-1:0] m_value_reg;
    logic                      m_last_reg;
    logic                      m_short_reg;
    logic                      m_ovf_reg;

    // combinational helpers
    logic                      s_accept;
    logic                      store_full;
    logic [CW-1:0]             cnt_after;
    logic [SC_W-1:0]           k_clamped;
    logic                      set_is_short;
    logic                      out_free;
    logic [CMPW:0]             idx_inc;
    logic                      emit_last;
    logic [CMPW-1:0]           lo_cmp;
    logic [CMPW-1:0]           k_cmp;

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == S_LOAD);
    assign s_accept     = s_valid && s_ready;
    assign store_full   = (load_count_reg == CW'(SET_DEPTH));
    assign cnt_after    = store_full ? load_count_reg : load_count_reg + CW'(1);
    assign set_is_short = (CMPW'(cnt_after) <= CMPW'(k_clamped));
    assign out_free     = !m_valid_reg || m_ready;
    assign idx_inc      = (CMPW + 1)'(out_idx_reg) + (CMPW + 1)'(1);
    assign emit_last    = (idx_inc == {1'b0, n_out_reg});
    assign lo_cmp       = CMPW'(lo_reg);
    assign k_cmp        = CMPW'(k_reg);

    // clamp k into 1..MAX_SELECT
    always_comb begin
        if (select_count_reg == '0) begin
            k_clamped = SC_W'(1);
        end else if (select_count_reg > SC_W'(MAX_SELECT)) begin
            k_clamped = SC_W'(MAX_SELECT);
        end else begin
            k_clamped = select_count_reg;
        end
    end

    // steer the single store port: one read or one write per step
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = lo_reg;
        mem_wdata = rdata_reg;
        mem_re    = 1'b0;
        mem_raddr = lo_reg;
        case (state_reg)
            S_LOAD: begin
                // store incoming values while there is room
                mem_we    = s_accept && !store_full;
                mem_waddr = load_count_reg[AW-1:0];
                mem_wdata = s_value;
            end
            S_PIV_RD: begin
                mem_re    = 1'b1;
                mem_raddr = range_low_reg;
            end
            S_HI_CHK: begin
                mem_re    = (lo_reg < hi_reg);
                mem_raddr = hi_reg;
            end
            S_HI_TEST: begin
                // element below pivot found on the right: fill the hole at lo
                mem_we    = (rdata_reg < pivot_value_reg);
                mem_waddr = lo_reg;
            end
            S_LO_CHK: begin
                mem_re    = (lo_reg < hi_reg);
                mem_raddr = lo_reg;
            end
            S_LO_TEST: begin
                // element at or above pivot found on the left: fill the hole at hi
                mem_we    = !(rdata_reg < pivot_value_reg);
                mem_waddr = hi_reg;
            end
            S_PLACE: begin
                // drop the pivot into its final position
                mem_we    = 1'b1;
                mem_waddr = lo_reg;
                mem_wdata = pivot_value_reg;
            end
            S_EMIT_RD: begin
                mem_re    = out_free;
                mem_raddr = out_idx_reg;
            end
            default: begin
                mem_we = 1'b0;
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            element_store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= element_store_mem[mem_raddr];
        end
    end

    // sequencer, datapath registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_LOAD;
            select_count_reg  <= SELECT_COUNT_RST;
            load_count_reg    <= '0;
            overflow_seen_reg <= 1'b0;
            range_low_reg     <= '0;
            range_high_reg    <= '0;
            pivot_value_reg   <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                select_count_reg <= cfg_data;
            end
            // retire the held result once taken
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_LOAD: begin
                    if (s_accept) begin
                        if (s_last) begin
                            // capture the set, then clear for the next one
                            k_reg             <= k_clamped;
                            ovf_reg           <= overflow_seen_reg || store_full;
                            short_reg         <= set_is_short;
                            out_idx_reg       <= '0;
                            range_low_reg     <= '0;
                            range_high_reg    <= AW'(cnt_after - CW'(1));
                            load_count_reg    <= '0;
                            overflow_seen_reg <= 1'b0;
                            if (set_is_short) begin
                                n_out_reg <= CMPW'(cnt_after);
                                state_reg <= S_EMIT_RD;
                            end else begin
                                n_out_reg <= CMPW'(k_clamped);
                                state_reg <= S_PIV_RD;
                            end
                        end else if (store_full) begin
                            overflow_seen_reg <= 1'b1;
                        end else begin
                            load_count_reg <= cnt_after;
                        end
                    end
                end
                S_PIV_RD: begin
                    lo_reg    <= range_low_reg;
                    hi_reg    <= range_high_reg;
                    state_reg <= S_PIV_LATCH;
                end
                S_PIV_LATCH: begin
                    pivot_value_reg <= rdata_reg;
                    state_reg       <= S_HI_CHK;
                end
                S_HI_CHK: begin
                    state_reg <= (lo_reg < hi_reg) ? S_HI_TEST : S_PLACE;
                end
                S_HI_TEST: begin
                    if (rdata_reg < pivot_value_reg) begin
                        state_reg <= S_LO_CHK;
                    end else begin
                        hi_reg    <= hi_reg - AW'(1);
                        state_reg <= S_HI_CHK;
                    end
                end
                S_LO_CHK: begin
                    state_reg <= (lo_reg < hi_reg) ? S_LO_TEST : S_PLACE;
                end
                S_LO_TEST: begin
                    if (rdata_reg < pivot_value_reg) begin
                        lo_reg    <= lo_reg + AW'(1);
                        state_reg <= S_LO_CHK;
                    end else begin
                        state_reg <= S_HI_CHK;
                    end
                end
                S_PLACE: begin
                    // narrow to the side that holds position k
                    if (lo_cmp == k_cmp) begin
                        out_idx_reg <= '0;
                        state_reg   <= S_EMIT_RD;
                    end else if (lo_cmp > k_cmp) begin
                        range_high_reg <= lo_reg - AW'(1);
                        state_reg      <= S_PIV_RD;
                    end else begin
                        range_low_reg <= lo_reg + AW'(1);
                        state_reg     <= S_PIV_RD;
                    end
                end
                S_EMIT_RD: begin
                    if (out_free) begin
                        state_reg <= S_EMIT_WAIT;
                    end
                end
                S_EMIT_WAIT: begin
                    m_valid_reg <= 1'b1;
                    m_value_reg <= rdata_reg;
                    m_last_reg  <= emit_last;
                    m_short_reg <= short_reg;
                    m_ovf_reg   <= ovf_reg;
                    out_idx_reg <= out_idx_reg + AW'(1);
                    state_reg   <= emit_last ? S_LOAD : S_EMIT_RD;
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value_out  = m_value_reg;
    assign m_last_out   = m_last_reg;
    assign m_short_set  = m_short_reg;
    assign m_overflowed = m_ovf_reg;

    // scans only run on a non-empty window
    `QSKS_ASSERT_IMPL(a_scan_window, aclk, aresetn,
        (state_reg == S_HI_TEST) || (state_reg == S_LO_TEST), lo_reg < hi_reg)

    // the pivot always lands inside the current range
    `QSKS_ASSERT_IMPL(a_pivot_in_range, aclk, aresetn, state_reg == S_PLACE,
        (lo_reg >= range_low_reg) && (lo_reg <= range_high_reg))

    // selection runs with a clamped, nonzero k
    `QSKS_ASSERT_IMPL(a_k_clamped, aclk, aresetn, state_reg != S_LOAD,
        (k_reg != '0) && (k_reg <= SC_W'(MAX_SELECT)))

endmodule

`default_nettype wire

// ===== tb/k_smallest_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// k_smallest_checker - result predictor and comparator for k-smallest select
// Follows every transaction on the cfg_, s_ and m_ channels, keeps its own
// copy of the loaded set and select count, runs the same first-pivot
// quickselect to predict each set's results and compares them in order.
// ---------------------------------------------------------------------------
module k_smallest_checker
    import qsks_pkg::*;
#(
    parameter int SET_DEPTH  = SET_DEPTH_DEF,
    parameter int MAX_SELECT = MAX_SELECT_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic [SC_W-1:0]           cfg_data,
    input  wire logic                      s_valid,
    input  wire logic                      s_ready,
    input  wire logic signed [VALUE_W-1:0] s_value,
    input  wire logic                      s_last,
    input  wire logic                      m_valid,
    input  wire logic                      m_ready,
    input  wire logic signed [VALUE_W-1:0] m_value_out,
    input  wire logic                      m_last_out,
    input  wire logic                      m_short_set,
    input  wire logic                      m_overflowed,
    output int                             mismatch_count,
    output int                             pending_count
);

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      is_last;
        logic                      short_set;
        logic                      overflowed;
    } smallest_t;

    logic signed [VALUE_W-1:0] set_store [SET_DEPTH];
    int                        set_len;
    logic                      set_overflow;
    logic [SC_W-1:0]           select_count;
    smallest_t                 pending_smallest [$];

    // Partition [lo_in, hi_in] around its first element by moving the hole;
    // return the position where the pivot settles.
    function automatic int split_at_pivot(input int lo_in, input int hi_in);
        int                        lo;
        int                        hi;
        logic signed [VALUE_W-1:0] pivot;
        lo    = lo_in;
        hi    = hi_in;
        pivot = set_store[lo];
        while (lo < hi) begin
            while (lo < hi && set_store[hi] >= pivot)
                hi--;
            set_store[lo] = set_store[hi];
            while (lo < hi && set_store[lo] < pivot)
                lo++;
            set_store[hi] = set_store[lo];
        end
        set_store[lo] = pivot;
        return lo;
    endfunction

    // Store one element; on the final one, select and queue the k smallest.
    task automatic accept_element(input logic signed [VALUE_W-1:0] v, input logic is_last);
        int        k;
        int        n;
        int        lo;
        int        hi;
        int        mid;
        logic      short_set;
        smallest_t r;
        if (set_len < SET_DEPTH) begin
            set_store[set_len] = v;
            set_len++;
        end else begin
            set_overflow = 1'b1;
        end
        if (is_last) begin
            k = int'(select_count);
            if (k == 0)
                k = 1;
            if (k > MAX_SELECT)
                k = MAX_SELECT;
            n         = set_len;
            short_set = (n <= k);
            if (!short_set) begin
                lo  = 0;
                hi  = n - 1;
                mid = split_at_pivot(lo, hi);
                while (mid != k) begin
                    if (mid > k)
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                    mid = split_at_pivot(lo, hi);
                end
                n = k;
            end
            for (int i = 0; i < n; i++) begin
                r.value      = set_store[i];
                r.is_last    = (i == n - 1);
                r.short_set  = short_set;
                r.overflowed = set_overflow;
                pending_smallest = {pending_smallest, r};
            end
            set_len      = 0;
            set_overflow = 1'b0;
        end
    endtask

    task automatic compare_result();
        smallest_t want;
        if (pending_smallest.size() == 0) begin
            $error("unexpected result: value_out %0d last_out %0b", m_value_out, m_last_out);
            mismatch_count++;
        end else begin
            want = pending_smallest.pop_front();
            if (m_value_out !== want.value) begin
                $error("value_out: expected %0d, got %0d", want.value, m_value_out);
                mismatch_count++;
            end
            if (m_last_out !== want.is_last) begin
                $error("last_out: expected %0b, got %0b", want.is_last, m_last_out);
                mismatch_count++;
            end
            if (m_short_set !== want.short_set) begin
                $error("short_set: expected %0b, got %0b", want.short_set, m_short_set);
                mismatch_count++;
            end
            if (m_overflowed !== want.overflowed) begin
                $error("overflowed: expected %0b, got %0b", want.overflowed, m_overflowed);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            set_len      = 0;
            set_overflow = 1'b0;
            select_count = SELECT_COUNT_RST;
            pending_smallest.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                select_count = cfg_data;
            if (s_valid && s_ready)
                accept_element(s_value, s_last);
            if (m_valid && m_ready)
                compare_result();
        end
        pending_count <= pending_smallest.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - top-level testbench for quickselect_k_smallest
// Loads directed and random sets under several select counts and idle
// patterns; the checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;
    import qsks_pkg::*;

    localparam int ROUND_ITEMS    = 6;    // random elements per round, at least
    localparam int OVERFLOW_ITEMS = 258;  // two past the store depth
    localparam int SETTLE_CYCLES  = 8;    // quiet cycles after the last result
    localparam int MAX_SET_LEN    = 70;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
    typedef enum {FILL_SPREAD, FILL_NARROW, FILL_RISING, FILL_FALLING} fill_kind_e;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [SC_W-1:0]           cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_value;
    logic                      s_last;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [VALUE_W-1:0] m_value_out;
    logic                      m_last_out;
    logic                      m_short_set;
    logic                      m_overflowed;

    int                        idle_pct;
    int                        stall_pct;
    int                        mismatch_count;
    int                        pending_count;
    logic signed [VALUE_W-1:0] set_values [$];

    quickselect_k_smallest DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value_out  (m_value_out),
        .m_last_out   (m_last_out),
        .m_short_set  (m_short_set),
        .m_overflowed (m_overflowed)
    );

    k_smallest_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value_out    (m_value_out),
        .m_last_out     (m_last_out),
        .m_short_set    (m_short_set),
        .m_overflowed   (m_overflowed),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver side: re-roll ready every cycle against the current stall rate.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #4_000_000;
        $display("quickselect_k_smallest verification failed");
        $finish;
    end

    task automatic apply_idle_mode(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                idle_pct  = 57;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                idle_pct  = 0;
                stall_pct = 57;
            end
            default: begin
                idle_pct  = 15;
                stall_pct = 15;
            end
        endcase
    endtask

    // Hold cfg_valid until the register write is taken, then drop it.
    task automatic write_select_count(input logic [SC_W-1:0] count);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Insert random idle cycles, then present one element and hold it until
    // the transaction completes. Valid stays high into the next call.
    task automatic send_element(input logic signed [VALUE_W-1:0] v, input logic is_last);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        s_last  <= is_last;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_set();
        for (int i = 0; i < set_values.size(); i++)
            send_element(set_values[i], i == set_values.size() - 1);
    endtask

    // Drop valid, wait for every expected result, then let the block settle
    // so a register write lands on an idle block.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Build a random set: wide random values with the extremes mixed in,
    // a narrow band full of ties, or runs sorted either way.
    task automatic fill_set(input int n);
        fill_kind_e                kind;
        logic signed [VALUE_W-1:0] v;
        kind = fill_kind_e'($urandom_range(0, 3));
        v    = $signed($urandom_range(0, 1000)) - 500;
        set_values.delete();
        for (int i = 0; i < n; i++) begin
            case (kind)
                FILL_SPREAD: begin
                    case ($urandom_range(0, 15))
                        0:       v = VALUE_MIN;
                        1:       v = VALUE_MAX;
                        default: v = $urandom;
                    endcase
                end
                FILL_NARROW:  v = $signed($urandom_range(0, 8)) - 4;
                FILL_RISING:  v = v + $signed($urandom_range(0, 3));
                default:      v = v - $signed($urandom_range(0, 3));
            endcase
            set_values = {set_values, v};
        end
    endtask

    // One phase: set the idle pattern and k, then stream random sets sized
    // around k so both short and partitioned sets come up.
    task automatic run_round(input idle_mode_e mode, input logic [SC_W-1:0] count);
        int sent;
        int k_eff;
        int cap;
        apply_idle_mode(mode);
        write_select_count(count);
        k_eff = (count == 0) ? 1 : ((count > MAX_SELECT_DEF) ? MAX_SELECT_DEF : int'(count));
        cap   = (2 * k_eff + 4 > MAX_SET_LEN) ? MAX_SET_LEN : 2 * k_eff + 4;
        sent  = 0;
        while (sent < ROUND_ITEMS) begin
            fill_set($urandom_range(1, cap));
            send_set();
            sent += set_values.size();
        end
        drain();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_value   = '0;
        s_last    = 1'b0;
        apply_idle_mode(IDLE_NONE);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset value of k (4): extremes, a single element, a set of exactly
        // k, and all-equal values one past k.
        set_values = '{VALUE_MIN, VALUE_MAX, -1, 0, 1};
        send_set();
        set_values = '{42};
        send_set();
        set_values = '{3, -3, 2, -2};
        send_set();
        set_values = '{7, 7, 7, 7, 7};
        send_set();
        drain();

        // A count of zero acts as one; feed a falling run.
        write_select_count(7'd0);
        set_values = '{5, 4, 3};
        send_set();
        drain();

        // Saturated count with a tiny set: returned whole in load order.
        write_select_count(7'd127);
        set_values = '{VALUE_MAX, VALUE_MIN};
        send_set();
        drain();

        write_select_count(7'd1);
        set_values = '{1, 2, 3, 4};
        send_set();
        drain();

        run_round(IDLE_NONE, 7'd1);
        run_round(IDLE_SENDER, 7'd0);

        // Overrun the store; the final element is itself dropped.
        apply_idle_mode(IDLE_RECEIVER);
        write_select_count(7'd5);
        fill_set(OVERFLOW_ITEMS);
        send_set();
        drain();

        run_round(IDLE_RECEIVER, 7'd7);
        run_round(IDLE_BOTH, 7'd127);
        run_round(IDLE_SENDER, 7'd3);
        run_round(IDLE_RECEIVER, 7'($urandom_range(0, 127)));

        // Watch a while longer for any stray result.
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("quickselect_k_smallest verification clean");
        end else begin
            $display("quickselect_k_smallest verification failed");
        end
        $finish;
    end

endmodule
